[design/msp_pkg.sv]
// Shared types, codes and constants of the step sequencer player.
`timescale 1ns / 1ps
package msp_pkg;

  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 8;

  localparam logic [3:0] OP_TIME   = 4'd0;
  localparam logic [3:0] OP_PAD    = 4'd1;
  localparam logic [3:0] OP_ROW    = 4'd2;
  localparam logic [3:0] OP_CHAN   = 4'd3;
  localparam logic [3:0] OP_SCENE  = 4'd4;
  localparam logic [3:0] OP_SELECT = 4'd5;
  localparam logic [3:0] OP_TOGGLE = 4'd6;
  localparam logic [3:0] OP_START  = 4'd7;
  localparam logic [3:0] OP_STOP   = 4'd8;

  localparam logic [1:0] CFG_TEMPO = 2'd0;
  localparam logic [1:0] CFG_SWING = 2'd1;

  localparam logic [8:0] TEMPO_RESET = 9'd120;
  localparam logic [8:0] TEMPO_MIN   = 9'd20;
  localparam logic [8:0] TEMPO_MAX   = 9'd300;
  localparam logic [6:0] SWING_RESET = 7'd50;
  localparam logic [6:0] SWING_MIN   = 7'd50;
  localparam logic [6:0] SWING_MAX   = 7'd99;
  localparam int         BAR_MS      = 240000;
  localparam int         SWING_DIV   = 50;
  localparam int         NOTE_CAP    = 32;
  localparam logic [3:0] HL_NONE     = 4'hF;

  localparam int DIV_W  = 20;
  localparam int DSR_W  = 12;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] now;
    logic [1:0]  pat;
    logic [1:0]  row;
    logic [2:0]  col;
    logic        pad_on;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [3:0]  chan;
    logic        p_ok;
    logic        r_ok;
    logic        c_ok;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] wait_ms;
    logic [3:0]  hl;
    logic        stepped;
    logic        last;
  } res_t;

endpackage

[design/msp_front.sv]
// Front end: takes items, checks address ranges, queues them for the back end.
`timescale 1ns / 1ps
module msp_front import msp_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] now_ms_i,
  input  logic [1:0]  pattern_index_i,
  input  logic [1:0]  row_index_i,
  input  logic [2:0]  column_index_i,
  input  logic        pad_on_i,
  input  logic [6:0]  note_value_i,
  input  logic [6:0]  velocity_value_i,
  input  logic [3:0]  channel_value_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.op     = operation_i;
    cmd_in.now    = now_ms_i;
    cmd_in.pat    = pattern_index_i;
    cmd_in.row    = row_index_i;
    cmd_in.col    = column_index_i;
    cmd_in.pad_on = pad_on_i;
    cmd_in.note   = note_value_i;
    cmd_in.vel    = velocity_value_i;
    cmd_in.chan   = channel_value_i;
    cmd_in.p_ok   = int'(pattern_index_i) < ROWS;
    cmd_in.r_ok   = int'(row_index_i) < ROWS;
    cmd_in.c_ok   = int'(column_index_i) < COLS;
  end

  assign busy_o      = (count_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

[design/msp_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module msp_div import msp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd_q, quo_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W:0]   rem_q, rem_sh, rem_sub;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             fits;

  assign rem_sh  = {rem_q[DSR_W-1:0], dvd_q[DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q <= fits ? rem_sub : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

[design/msp_back.sv]
// Back end: sequencer state, note walk over rows and patterns, step timing.
`timescale 1ns / 1ps
module msp_back import msp_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  input  logic [8:0] tempo_i,
  input  logic [6:0] swing_i,
  output res_t       res_o
);

  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int NCW = $clog2(NOTE_CAP + 1);
  localparam logic [RW-1:0] LAST_R = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_C = CW'(COLS - 1);

  // swing divisor is a constant: reciprocal multiply, exact for 20-bit products
  localparam longint unsigned SW_DEN = longint'(SWING_DIV * COLS);
  localparam int              SW_SH  = 32;
  localparam int              RCP_W  = 26;
  localparam logic [RCP_W-1:0] SW_RCP =
    RCP_W'(((64'd1 << SW_SH) + SW_DEN - 64'd1) / SW_DEN);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_REL   = 4'd1;
  localparam logic [3:0] ST_PAD   = 4'd2;
  localparam logic [3:0] ST_PEND  = 4'd3;
  localparam logic [3:0] ST_COPY  = 4'd4;
  localparam logic [3:0] ST_SRELC = 4'd5;
  localparam logic [3:0] ST_SACT  = 4'd6;
  localparam logic [3:0] ST_SADVC = 4'd7;
  localparam logic [3:0] ST_SEND  = 4'd8;
  localparam logic [3:0] ST_DIVS  = 4'd9;
  localparam logic [3:0] ST_DIVW  = 4'd10;
  localparam logic [3:0] ST_STATT = 4'd11;
  localparam logic [3:0] ST_STATZ = 4'd12;

  localparam logic [1:0] CTX_STOP = 2'd0;
  localparam logic [1:0] CTX_PAT  = 2'd1;
  localparam logic [1:0] CTX_SREL = 2'd2;
  localparam logic [1:0] CTX_SADV = 2'd3;

  logic [ROWS-1:0][COLS-1:0] pad_q [ROWS];
  logic [13:0]               rnote_q [ROWS][ROWS];
  logic [3:0]                pch_q [ROWS];
  logic [ROWS-1:0][COLS-1:0] scene_q;
  logic [7:0]                held_q [ROWS][ROWS];
  logic [3:0]                hch_q [ROWS];
  logic [CW-1:0]             pcol_q [ROWS];
  logic [RW-1:0]             play_q, sel_q, old_q, cp_q, pi_q, ri_q;
  logic                      scene_mode_q, scene_req_q, running_q;
  logic [CW-1:0]             scol_q, step_q;
  logic [ROWS-1:0]           active_q;
  logic [31:0]               next_q, swd_q;
  logic [3:0]                hl_q;
  logic [1:0]                ctx_q, dsel_q;
  logic [NCW-1:0]            ncnt_q;
  logic [3:0]                state_q;
  logic [31:0]               now_q;
  logic [DIV_W-1:0]          q1_q, swprod_q, swq_q;
  res_t                      res_q;

  logic [7:0]             h_cur;
  logic [13:0]            rn_cur;
  logic                   pad_bit;
  logic                   note_emit;
  logic [3:0]             note_ch;
  logic [6:0]             note_nt, note_vel;
  logic [8:0]             tempo_c;
  logic [6:0]             swing_c;
  logic [5:0]             sw_off;
  logic                   div_start, div_busy, div_done;
  logic [DIV_W-1:0]       div_dvd, div_quot;
  logic [DSR_W-1:0]       div_dsr;
  logic [DIV_W+RCP_W-1:0] sw_mul;
  logic [31:0]            when_ms, target_ms;
  logic [CW-1:0]          scol_nx;
  logic [RW-1:0]          cp_in, cr_in;
  logic [CW-1:0]          cc_in;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_o     = res_q;
  assign cp_in     = RW'(cmd_i.pat);
  assign cr_in     = RW'(cmd_i.row);
  assign cc_in     = CW'(cmd_i.col);
  assign when_ms   = next_q + swd_q;
  assign target_ms = next_q + swd_q;
  assign scol_nx   = (scol_q == LAST_C) ? '0 : scol_q + 1'b1;
  assign sw_mul    = swprod_q * SW_RCP;

  always_comb begin
    h_cur   = held_q[cp_q][ri_q];
    rn_cur  = rnote_q[cp_q][ri_q];
    pad_bit = pad_q[cp_q][ri_q][pcol_q[cp_q]];
    note_emit = 1'b0;
    note_ch   = '0;
    note_nt   = '0;
    note_vel  = '0;
    if (state_q == ST_REL && h_cur[7]) begin
      note_emit = 1'b1;
      note_ch   = hch_q[cp_q];
      note_nt   = h_cur[6:0];
    end else if (state_q == ST_PAD && pad_bit) begin
      note_emit = 1'b1;
      note_ch   = pch_q[cp_q];
      note_nt   = rn_cur[6:0];
      note_vel  = rn_cur[13:7];
    end
  end

  always_comb begin
    tempo_c = tempo_i;
    if (tempo_i < TEMPO_MIN) tempo_c = TEMPO_MIN;
    if (tempo_i > TEMPO_MAX) tempo_c = TEMPO_MAX;
    swing_c = swing_i;
    if (swing_i < SWING_MIN) swing_c = SWING_MIN;
    if (swing_i > SWING_MAX) swing_c = SWING_MAX;
    sw_off = 6'(swing_c - SWING_MIN);
  end

  // Two passes through the divider: bar/tempo, then bar/(tempo*cols), which
  // equals the truncated step period.
  always_comb begin
    div_start = (state_q == ST_DIVS);
    div_dvd   = DIV_W'(BAR_MS);
    case (dsel_q)
      2'd0:    div_dsr = DSR_W'(tempo_c);
      default: div_dsr = DSR_W'(32'(tempo_c) * COLS);
    endcase
  end

  msp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        pad_q[i]  <= '0;
        pch_q[i]  <= '0;
        hch_q[i]  <= '0;
        pcol_q[i] <= '0;
        for (int j = 0; j < ROWS; j++) begin
          rnote_q[i][j] <= '0;
          held_q[i][j]  <= '0;
        end
      end
      scene_q      <= '0;
      play_q       <= '0;
      sel_q        <= '0;
      old_q        <= '0;
      cp_q         <= '0;
      pi_q         <= '0;
      ri_q         <= '0;
      scene_mode_q <= 1'b0;
      scene_req_q  <= 1'b0;
      running_q    <= 1'b0;
      scol_q       <= '0;
      step_q       <= '0;
      active_q     <= '0;
      next_q       <= '0;
      swd_q        <= '0;
      hl_q         <= HL_NONE;
      ctx_q        <= CTX_STOP;
      dsel_q       <= '0;
      ncnt_q       <= '0;
      state_q      <= ST_IDLE;
      now_q        <= '0;
      q1_q         <= '0;
      swprod_q     <= '0;
      swq_q        <= '0;
      res_q        <= '0;
    end else begin
      res_q <= '0;
      if (note_emit && ncnt_q < NCW'(NOTE_CAP)) begin
        res_q.valid <= 1'b1;
        res_q.chan  <= note_ch;
        res_q.note  <= note_nt;
        res_q.vel   <= note_vel;
        ncnt_q      <= ncnt_q + 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            now_q  <= cmd_i.now;
            dsel_q <= '0;
            ncnt_q <= '0;
            res_q.kind <= 1'b1;
            res_q.last <= 1'b1;
            res_q.hl   <= hl_q;
            case (cmd_i.op)
              OP_TIME: begin
                if (!running_q) begin
                  res_q.valid <= 1'b1;
                end else if (when_ms > cmd_i.now) begin
                  res_q.valid   <= 1'b1;
                  res_q.wait_ms <= when_ms - cmd_i.now;
                end else if (scene_mode_q) begin
                  pi_q <= '0;
                  if (step_q == '0) begin
                    hl_q    <= 4'(scol_q);
                    state_q <= ST_SRELC;
                  end else begin
                    state_q <= ST_SADVC;
                  end
                end else begin
                  if (play_q == sel_q && !scene_req_q) hl_q <= 4'(pcol_q[play_q]);
                  cp_q    <= play_q;
                  ri_q    <= '0;
                  ctx_q   <= CTX_PAT;
                  state_q <= ST_REL;
                end
              end
              OP_PAD: begin
                if (cmd_i.p_ok && cmd_i.r_ok && cmd_i.c_ok)
                  pad_q[cp_in][cr_in][cc_in] <= cmd_i.pad_on;
                res_q.valid <= 1'b1;
              end
              OP_ROW: begin
                if (cmd_i.p_ok && cmd_i.r_ok) rnote_q[cp_in][cr_in] <= {cmd_i.vel, cmd_i.note};
                res_q.valid <= 1'b1;
              end
              OP_CHAN: begin
                if (cmd_i.p_ok) pch_q[cp_in] <= cmd_i.chan;
                res_q.valid <= 1'b1;
              end
              OP_SCENE: begin
                if (cmd_i.r_ok && cmd_i.c_ok) scene_q[cr_in][cc_in] <= cmd_i.pad_on;
                res_q.valid <= 1'b1;
              end
              OP_SELECT: begin
                if (cmd_i.p_ok) sel_q <= cp_in;
                res_q.valid <= 1'b1;
              end
              OP_TOGGLE: begin
                scene_req_q <= !scene_req_q;
                res_q.valid <= 1'b1;
              end
              OP_START: begin
                play_q         <= sel_q;
                pcol_q[sel_q]  <= '0;
                next_q         <= cmd_i.now;
                scene_mode_q   <= scene_req_q;
                scol_q         <= '0;
                active_q       <= '0;
                step_q         <= '0;
                swd_q          <= '0;
                running_q      <= 1'b1;
                res_q.valid    <= 1'b1;
              end
              OP_STOP: begin
                res_q.kind <= 1'b0;
                res_q.last <= 1'b0;
                res_q.hl   <= '0;
                cp_q    <= play_q;
                ri_q    <= '0;
                ctx_q   <= CTX_STOP;
                state_q <= ST_REL;
              end
              default: begin
                res_q.valid <= 1'b1;
              end
            endcase
          end
        end
        ST_REL: begin
          if (h_cur[7]) held_q[cp_q][ri_q] <= '0;
          if (ri_q == LAST_R) begin
            ri_q <= '0;
            case (ctx_q)
              CTX_STOP: begin
                hl_q      <= HL_NONE;
                running_q <= 1'b0;
                state_q   <= ST_STATZ;
              end
              CTX_SREL: state_q <= ST_SACT;
              default:  state_q <= ST_PAD;
            endcase
          end else begin
            ri_q <= ri_q + 1'b1;
          end
        end
        ST_PAD: begin
          if (pad_bit) held_q[cp_q][ri_q] <= {1'b1, rn_cur[6:0]};
          if (ri_q == LAST_R) begin
            ri_q        <= '0;
            hch_q[cp_q] <= pch_q[cp_q];
            pcol_q[cp_q] <= (pcol_q[cp_q] == LAST_C) ? '0 : pcol_q[cp_q] + 1'b1;
            if (ctx_q == CTX_PAT) begin
              state_q <= ST_PEND;
            end else if (pi_q == LAST_R) begin
              state_q <= ST_SEND;
            end else begin
              pi_q    <= pi_q + 1'b1;
              state_q <= ST_SADVC;
            end
          end else begin
            ri_q <= ri_q + 1'b1;
          end
        end
        ST_PEND: begin
          state_q <= ST_DIVS;
          if (step_q == LAST_C) begin
            step_q <= '0;
            if (scene_req_q) scene_mode_q <= 1'b1;
            if (play_q != sel_q) begin
              // new pattern inherits the held notes of the old one
              old_q         <= play_q;
              play_q        <= sel_q;
              hch_q[sel_q]  <= hch_q[play_q];
              pcol_q[sel_q] <= '0;
              ri_q          <= '0;
              state_q       <= ST_COPY;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_COPY: begin
          held_q[play_q][ri_q] <= held_q[old_q][ri_q];
          if (ri_q == LAST_R) begin
            ri_q    <= '0;
            state_q <= ST_DIVS;
          end else begin
            ri_q <= ri_q + 1'b1;
          end
        end
        ST_SRELC: begin
          if (active_q[pi_q]) begin
            cp_q    <= pi_q;
            ri_q    <= '0;
            ctx_q   <= CTX_SREL;
            state_q <= ST_REL;
          end else begin
            state_q <= ST_SACT;
          end
        end
        ST_SACT: begin
          active_q[pi_q] <= scene_q[pi_q][scol_q];
          if (pi_q == LAST_R) begin
            pi_q    <= '0;
            state_q <= ST_SADVC;
          end else begin
            pi_q    <= pi_q + 1'b1;
            state_q <= ST_SRELC;
          end
        end
        ST_SADVC: begin
          if (active_q[pi_q]) begin
            cp_q    <= pi_q;
            ri_q    <= '0;
            ctx_q   <= CTX_SADV;
            state_q <= ST_REL;
          end else if (pi_q == LAST_R) begin
            state_q <= ST_SEND;
          end else begin
            pi_q <= pi_q + 1'b1;
          end
        end
        ST_SEND: begin
          state_q <= ST_DIVS;
          if (step_q == LAST_C) begin
            step_q <= '0;
            scol_q <= scol_nx;
            if (!scene_req_q) scene_mode_q <= 1'b0;
            else hl_q <= 4'(scol_nx);
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DIVS: begin
          state_q <= ST_DIVW;
        end
        ST_DIVW: begin
          // swing product and its scaled quotient settle during the second pass
          if (dsel_q != 2'd0) begin
            swprod_q <= DIV_W'({14'd0, sw_off} * q1_q);
            swq_q    <= DIV_W'(sw_mul >> SW_SH);
          end
          if (div_done) begin
            case (dsel_q)
              2'd0: begin
                q1_q    <= div_quot;
                dsel_q  <= 2'd1;
                state_q <= ST_DIVS;
              end
              default: begin
                next_q  <= next_q + 32'(div_quot);
                swd_q   <= step_q[0] ? '0 : 32'(swq_q);
                state_q <= ST_STATT;
              end
            endcase
          end
        end
        ST_STATT: begin
          res_q.valid   <= 1'b1;
          res_q.kind    <= 1'b1;
          res_q.wait_ms <= (target_ms > now_q) ? target_ms - now_q : '0;
          res_q.hl      <= hl_q;
          res_q.stepped <= 1'b1;
          res_q.last    <= 1'b1;
          state_q       <= ST_IDLE;
        end
        ST_STATZ: begin
          res_q.valid <= 1'b1;
          res_q.kind  <= 1'b1;
          res_q.hl    <= hl_q;
          res_q.last  <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_note_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= NCW'(NOTE_CAP)) else $error("note count past cap");

  a_note_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.valid && !res_q.kind) |-> !res_q.last) else $error("note marked last");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy) else $error("divider busy while idle");

  a_step_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STATT) |-> running_q) else $error("step status while stopped");

endmodule

[design/midi_step_sequencer_player.sv]
// Top level of the grid step sequencer player with swing.
//
// Items enter on start_i with the operation fields; an item is taken at a
// clock edge with start_i high and busy_o low. A two-item queue sits between
// the front end and the back end, so busy_o rises only when it is full.
// Every item returns zero or more note results (kind 0) and then one status
// result (kind 1, last 1), each shown for one cycle with result_valid_o.
// The receiver cannot stall; results are simply presented.
// Writes, selects and not-yet-due time items are answered from the idle state.
// Stop releases the held notes row by row, then returns its status.
// A due time item walks one row per cycle: release and then pad rows for each
// played pattern (plus a held-note copy at bar end, and the scene release
// and activation walk on the first step of a scene bar), then two passes
// through the shared divider for bar length and step period; the swing delay
// is formed alongside by a reciprocal multiply.
// Config writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered at the next clock edge.
// Reset clears all grids, notes, held notes and the timing state, and sets
// tempo 120 and swing 50.
`timescale 1ns / 1ps
module midi_step_sequencer_player import msp_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [3:0]        operation_i,
  input  logic [31:0]       now_ms_i,
  input  logic [1:0]        pattern_index_i,
  input  logic [1:0]        row_index_i,
  input  logic [2:0]        column_index_i,
  input  logic              pad_on_i,
  input  logic [6:0]        note_value_i,
  input  logic [6:0]        velocity_value_i,
  input  logic [3:0]        channel_value_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  output logic              result_valid_o,
  output logic              kind_o,
  output logic [3:0]        midi_channel_o,
  output logic [6:0]        midi_note_o,
  output logic [6:0]        midi_velocity_o,
  output logic [31:0]       wait_ms_o,
  output logic signed [3:0] highlight_column_o,
  output logic              stepped_o,
  output logic              last_o
);

  logic [8:0] tempo_q;
  logic [6:0] swing_q;
  cmd_t       cmd;
  logic       cmd_valid, cmd_pop;
  res_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= TEMPO_RESET;
      swing_q <= SWING_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_TEMPO) tempo_q <= cfg_data_i;
      if (cfg_index_i == CFG_SWING) swing_q <= cfg_data_i[6:0];
    end
  end

  msp_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .now_ms_i         (now_ms_i),
    .pattern_index_i  (pattern_index_i),
    .row_index_i      (row_index_i),
    .column_index_i   (column_index_i),
    .pad_on_i         (pad_on_i),
    .note_value_i     (note_value_i),
    .velocity_value_i (velocity_value_i),
    .channel_value_i  (channel_value_i),
    .cmd_o            (cmd),
    .cmd_valid_o      (cmd_valid),
    .cmd_pop_i        (cmd_pop)
  );

  msp_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .tempo_i     (tempo_q),
    .swing_i     (swing_q),
    .res_o       (res)
  );

  assign result_valid_o     = res.valid;
  assign kind_o             = res.kind;
  assign midi_channel_o     = res.chan;
  assign midi_note_o        = res.note;
  assign midi_velocity_o    = res.vel;
  assign wait_ms_o          = res.wait_ms;
  assign highlight_column_o = $signed(res.hl);
  assign stepped_o          = res.stepped;
  assign last_o             = res.last;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the step sequencer player: command driver, result monitor, predictor.
`timescale 1ns / 1ps
module tb_top;
  import msp_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] now;
    logic [1:0]  pat;
    logic [1:0]  row;
    logic [2:0]  col;
    logic        pad_on;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [3:0]  chan;
  } seq_item_t;

  typedef struct {
    logic        kind;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] wait_ms;
    logic [3:0]  hl;
    logic        stepped;
    logic        last;
  } seq_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [3:0] operation_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [1:0] pattern_index_i = '0;
  logic [1:0] row_index_i = '0;
  logic [2:0] column_index_i = '0;
  logic pad_on_i = 1'b0;
  logic [6:0] note_value_i = '0;
  logic [6:0] velocity_value_i = '0;
  logic [3:0] channel_value_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic busy_o, result_valid_o, kind_o, stepped_o, last_o;
  logic [3:0] midi_channel_o;
  logic [6:0] midi_note_o, midi_velocity_o;
  logic [31:0] wait_ms_o;
  logic signed [3:0] highlight_column_o;

  midi_step_sequencer_player u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] pad_grid [4];
  logic [13:0] row_notes [4][4];
  logic [3:0]  pat_chan [4];
  logic [31:0] scene_grid;
  logic [7:0]  held [4][4];
  logic [3:0]  held_chan [4];
  int unsigned pat_col [4];
  int unsigned play_idx, sel_pat, scene_col, step_cnt;
  bit          scene_mode, scene_req, running;
  logic [3:0]  scene_act;
  logic [31:0] next_ms, swing_ms;
  logic [3:0]  hl;
  int unsigned tempo_reg, swing_reg;
  int          n_notes;

  seq_out_t  expected_results[$];
  seq_item_t pending[$];
  seq_item_t cur_item;
  int        idle_pct = 0;
  int        errors = 0;
  logic [31:0] clock_ms = 0;

  function automatic void push_note(logic [3:0] ch, logic [6:0] nt, logic [6:0] vl);
    seq_out_t o;
    if (n_notes >= NOTE_CAP) return;
    o = '{1'b0, ch, nt, vl, 32'd0, 4'd0, 1'b0, 1'b0};
    expected_results.push_back(o);
    n_notes++;
  endfunction

  function automatic void push_status(logic [31:0] w, logic st);
    seq_out_t o;
    o = '{1'b1, 4'd0, 7'd0, 7'd0, w, hl, st, 1'b1};
    expected_results.push_back(o);
  endfunction

  function automatic void release_held(int unsigned p);
    for (int r = 0; r < 4; r++) begin
      if (held[p][r][7]) begin
        push_note(held_chan[p], held[p][r][6:0], 7'd0);
        held[p][r] = '0;
      end
    end
  endfunction

  function automatic void advance_pat(int unsigned p);
    release_held(p);
    for (int r = 0; r < 4; r++) begin
      if (pad_grid[p][r*8 + pat_col[p]]) begin
        push_note(pat_chan[p], row_notes[p][r][6:0], row_notes[p][r][13:7]);
        held[p][r] = {1'b1, row_notes[p][r][6:0]};
      end
    end
    held_chan[p] = pat_chan[p];
    pat_col[p] = (pat_col[p] + 1) % 8;
  endfunction

  function automatic void tick_pat();
    int unsigned old;
    old = play_idx;
    if (play_idx == sel_pat && !scene_req) hl = pat_col[play_idx];
    advance_pat(play_idx);
    if (++step_cnt >= 8) begin
      step_cnt = 0;
      if (play_idx != sel_pat) begin
        play_idx = sel_pat;
        held[play_idx] = held[old];
        held_chan[play_idx] = held_chan[old];
        pat_col[play_idx] = 0;
      end
      if (scene_req) scene_mode = 1;
    end
  endfunction

  function automatic void tick_scn();
    if (step_cnt == 0) begin
      hl = scene_col;
      for (int i = 0; i < 4; i++) begin
        if (scene_act[i]) release_held(i);
        scene_act[i] = scene_grid[i*8 + scene_col];
      end
    end
    for (int i = 0; i < 4; i++)
      if (scene_act[i]) advance_pat(i);
    if (++step_cnt >= 8) begin
      step_cnt = 0;
      scene_col = (scene_col + 1) % 8;
      if (!scene_req) scene_mode = 0;
      else hl = scene_col;
    end
  endfunction

  function automatic int unsigned clamp_tempo();
    return tempo_reg < 20 ? 20 : (tempo_reg > 300 ? 300 : tempo_reg);
  endfunction

  function automatic void predict_item(seq_item_t it);
    logic [31:0] due, tgt, bar;
    int unsigned sw;
    n_notes = 0;
    case (it.op)
      OP_TIME: begin
        if (running) begin
          due = next_ms + swing_ms;
          if (due > it.now) begin
            push_status(due - it.now, 1'b0);
            return;
          end
          if (scene_mode) tick_scn();
          else tick_pat();
          bar = 240000 / clamp_tempo();
          sw = swing_reg < 50 ? 50 : (swing_reg > 99 ? 99 : swing_reg);
          next_ms = next_ms + bar / 8;
          swing_ms = (step_cnt[0] == 0) ? ((sw - 50) * bar) / 400 : 0;
          tgt = next_ms + swing_ms;
          push_status(tgt > it.now ? tgt - it.now : 32'd0, 1'b1);
          return;
        end
      end
      OP_PAD:    pad_grid[it.pat][it.row*8 + it.col] = it.pad_on;
      OP_ROW:    row_notes[it.pat][it.row] = {it.vel, it.note};
      OP_CHAN:   pat_chan[it.pat] = it.chan;
      OP_SCENE:  scene_grid[it.row*8 + it.col] = it.pad_on;
      OP_SELECT: sel_pat = it.pat;
      OP_TOGGLE: scene_req = !scene_req;
      OP_START: begin
        play_idx = sel_pat;
        pat_col[play_idx] = 0;
        next_ms = it.now;
        scene_mode = scene_req;
        scene_col = 0;
        scene_act = '0;
        step_cnt = 0;
        swing_ms = 0;
        running = 1;
      end
      OP_STOP: begin
        release_held(play_idx);
        hl = HL_NONE;
        running = 0;
      end
      default: ;
    endcase
    push_status(32'd0, 1'b0);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) predict_item(cur_item);
      if (!start_i || !busy_o) begin
        if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = pending.pop_front();
          operation_i <= cur_item.op;
          now_ms_i <= cur_item.now;
          pattern_index_i <= cur_item.pat;
          row_index_i <= cur_item.row;
          column_index_i <= cur_item.col;
          pad_on_i <= cur_item.pad_on;
          note_value_i <= cur_item.note;
          velocity_value_i <= cur_item.vel;
          channel_value_i <= cur_item.chan;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk_i) begin
    seq_out_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result, kind %0d", kind_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, kind_o);
        check_field("midi_channel", e.chan, midi_channel_o);
        check_field("midi_note", e.note, midi_note_o);
        check_field("midi_velocity", e.vel, midi_velocity_o);
        check_field("wait_ms", e.wait_ms, wait_ms_o);
        check_field("highlight_column", e.hl, $unsigned(highlight_column_o));
        check_field("stepped", e.stepped, stepped_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  function automatic seq_item_t rand_item(logic [3:0] op);
    seq_item_t it;
    it.op = op;
    it.now = clock_ms;
    it.pat = $urandom_range(3);
    it.row = $urandom_range(3);
    it.col = $urandom_range(7);
    it.pad_on = $urandom_range(1);
    it.note = $urandom_range(127);
    it.vel = $urandom_range(127);
    it.chan = $urandom_range(15);
    return it;
  endfunction

  function automatic void add(logic [3:0] op);
    pending.push_back(rand_item(op));
  endfunction

  // time moves forward mostly by up to two steps, now and then jumps anywhere
  function automatic void add_tick();
    int unsigned step;
    step = 240000 / clamp_tempo() / 8;
    if ($urandom_range(99) < 4) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 2 * step);
    add(OP_TIME);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TEMPO) tempo_reg = data;
    else swing_reg = data[6:0];
  endtask

  task automatic drain();
    while (pending.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    int unsigned r;
    int tempos[6] = '{120, 300, 20, 0, 511, 150};
    int swings[6] = '{50, 99, 50, 0, 127, 75};
    int idles[6] = '{0, 59, 34, 0, 59, 34};
    for (int p = 0; p < 4; p++) begin
      pad_grid[p] = '0; pat_chan[p] = '0; held_chan[p] = '0; pat_col[p] = 0;
      for (int q = 0; q < 4; q++) begin
        row_notes[p][q] = '0; held[p][q] = '0;
      end
    end
    scene_grid = '0; play_idx = 0; sel_pat = 0; scene_mode = 0; scene_req = 0;
    scene_col = 0; scene_act = '0; step_cnt = 0; next_ms = '0; swing_ms = '0;
    hl = HL_NONE; running = 0; tempo_reg = TEMPO_RESET; swing_reg = SWING_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle block, extremes, every operation
    add(OP_TIME);
    add(OP_STOP);
    add(4'd9);
    add(4'd15);
    pending.push_back('{OP_ROW, 0, 2'd0, 2'd0, 3'd0, 1'b0, 7'd127, 7'd127, 4'd0});
    pending.push_back('{OP_ROW, 0, 2'd0, 2'd3, 3'd0, 1'b0, 7'd0, 7'd0, 4'd0});
    pending.push_back('{OP_CHAN, 0, 2'd0, 2'd0, 3'd0, 1'b0, 7'd0, 7'd0, 4'd15});
    pending.push_back('{OP_PAD, 0, 2'd0, 2'd0, 3'd0, 1'b1, 7'd0, 7'd0, 4'd0});
    pending.push_back('{OP_PAD, 0, 2'd0, 2'd3, 3'd7, 1'b1, 7'd0, 7'd0, 4'd0});
    pending.push_back('{OP_PAD, 0, 2'd0, 2'd3, 3'd0, 1'b1, 7'd0, 7'd0, 4'd0});
    pending.push_back('{OP_SCENE, 0, 2'd0, 2'd3, 3'd7, 1'b1, 7'd0, 7'd0, 4'd0});
    clock_ms = 32'hFFFF_FF00;
    add(OP_START);
    add(OP_TIME);
    clock_ms = clock_ms + 100;
    add(OP_TIME);
    clock_ms = clock_ms + 200;
    add(OP_TIME);
    pending.push_back('{OP_SELECT, 0, 2'd3, 2'd0, 3'd0, 1'b0, 7'd0, 7'd0, 4'd0});
    add(OP_TOGGLE);
    for (int i = 0; i < 3; i++) add_tick();
    add(OP_STOP);
    add(OP_TOGGLE);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_TEMPO, tempos[ph]);
      write_reg(CFG_SWING, swings[ph]);
      idle_pct = idles[ph];
      add(OP_START);
      for (int i = 0; i < 65; i++) begin
        r = $urandom_range(99);
        if (r < 55) add_tick();
        else if (r < 67) add(OP_PAD);
        else if (r < 73) add(OP_ROW);
        else if (r < 76) add(OP_CHAN);
        else if (r < 84) add(OP_SCENE);
        else if (r < 89) add(OP_SELECT);
        else if (r < 92) add(OP_TOGGLE);
        else if (r < 95) add(OP_START);
        else if (r < 97) add(OP_STOP);
        else add(4'd9 + $urandom_range(6));
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
design/msp_pkg.sv
design/msp_front.sv
design/msp_div.sv
design/msp_back.sv
design/midi_step_sequencer_player.sv
tb/tb_top.sv
